/* rtl/signed_int_to_decimal_ascii_core_macros.svh */
// Assertion macros shared by the signed integer to decimal text modules.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SITDA_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sitda assertion failed");
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitda assertion failed");
`else
`define SITDA_ASSERT(lbl, clk, rst_n, expr)
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/sitda_pkg.sv */
// Shared types, constants and helper functions for the decimal text converter.
package sitda_pkg;

    localparam int DATA_BITS_DEF = 32;
    localparam int JOB_Q_DEPTH   = 2;
    localparam int OUT_Q_DEPTH   = 2;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_job_ctl;

    // Decimal digits needed for the largest magnitude, 2**(bits-1).
    function automatic int dec_digits(input int bits);
        logic [64:0] v;
        int          n;
        v = 65'd1 << (bits - 1);
        n = 1;
        for (int k = 0; k < 20; k++) begin
            if (v >= 65'd10) begin
                v = v / 65'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

/* rtl/signed_int_to_decimal_ascii_core.sv */
// Flow: a request waits in the job queue until the back end is idle and takes it; the
//   bit-serial BCD shift loop then takes most of the conversion time, after which an optional
//   minus sign and the digits go out, stepping past suppressed leading zeros in turn. Emission
//   stalls while the result queue is full; new requests queue while a conversion runs.
// A two-entry job queue and a two-entry result queue decouple both sides.
// Reset (synchronous, active low) empties both queues and idles the converter.
module signed_int_to_decimal_ascii_core #(
    parameter int DATA_BITS = sitda_pkg::DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [DATA_BITS-1:0] i_value,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [7:0]           o_character,
    output logic                 o_last
);

    sitda_pkg::t_job_ctl  job;
    logic [DATA_BITS-1:0] job_mag;
    logic                 job_take;
    logic                 out_push;
    logic [7:0]           out_char;
    logic                 out_last;
    logic                 out_full;

    sitda_front #(
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_value    (i_value),
        .o_job      (job),
        .o_job_mag  (job_mag),
        .i_job_take (job_take)
    );

    sitda_back #(
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job),
        .i_job_mag  (job_mag),
        .o_job_take (job_take),
        .o_out_push (out_push),
        .o_out_char (out_char),
        .o_out_last (out_last),
        .i_out_full (out_full)
    );

    sitda_fifo #(
        .WIDTH (9),
        .DEPTH (sitda_pkg::OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  ({out_last, out_char}),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  ({o_last, o_character}),
        .o_empty (o_empty)
    );

endmodule

/* rtl/sitda_fifo.sv */
// Small register queue with push/full and pop/empty sides.
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitda_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sitda_pkg::JOB_Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CNTW-1:0]  r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_slot[r_wr] <= i_data;
                r_wr         <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    `SITDA_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNTW'(DEPTH))
    `SITDA_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, do_push && !do_pop, r_cnt == $past(r_cnt) + CNTW'(1))
    `SITDA_ASSERT_NEXT(a_cnt_down, i_clk, i_rst_n, do_pop && !do_push, r_cnt == $past(r_cnt) - CNTW'(1))

endmodule

/* rtl/sitda_front.sv */
// Front end: accepts requests, splits sign and magnitude, queues the job.
module sitda_front #(
    parameter int DATA_BITS = sitda_pkg::DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [DATA_BITS-1:0] i_value,
    output sitda_pkg::t_job_ctl  o_job,
    output logic [DATA_BITS-1:0] o_job_mag,
    input  logic                 i_job_take
);

    logic                 neg;
    logic [DATA_BITS-1:0] mag;
    logic [DATA_BITS:0]   q_out;
    logic                 q_empty;

    // Magnitude in an unsigned word, so the most negative value stays exact.
    assign neg = i_value[DATA_BITS-1];
    assign mag = neg ? (~i_value + DATA_BITS'(1)) : i_value;

    sitda_fifo #(
        .WIDTH (DATA_BITS + 1),
        .DEPTH (sitda_pkg::JOB_Q_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  ({neg, mag}),
        .o_full  (o_full),
        .i_pop   (i_job_take),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign o_job.valid = !q_empty;
    assign o_job.neg   = q_out[DATA_BITS];
    assign o_job_mag   = q_out[DATA_BITS-1:0];

endmodule

/* rtl/sitda_back.sv */
// Back end: bit-serial binary to BCD conversion, then character emission.
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitda_back #(
    parameter int DATA_BITS = sitda_pkg::DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sitda_pkg::t_job_ctl  i_job,
    input  logic [DATA_BITS-1:0] i_job_mag,
    output logic                 o_job_take,
    output logic                 o_out_push,
    output logic [7:0]           o_out_char,
    output logic                 o_out_last,
    input  logic                 i_out_full
);

    localparam int NDIG = sitda_pkg::dec_digits(DATA_BITS);
    localparam int BW   = 4 * NDIG;
    localparam int IW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int CW   = $clog2(DATA_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic                 r_neg;
    logic                 r_started;
    logic [DATA_BITS-1:0] r_sh;
    logic [BW-1:0]        r_bcd;
    logic [CW-1:0]        r_cnt;
    logic [IW-1:0]        r_idx;

    logic [BW-1:0]        bcd_adj;
    logic [3:0]           digit;
    logic                 skip;

    // Add-3 correction on every digit before each shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                           : r_bcd[4*i +: 4];
        end
    end

    assign digit = r_bcd[4*r_idx +: 4];
    // Leading zeros are dropped, but the units digit always goes out.
    assign skip  = !r_started && (digit == 4'd0) && (r_idx != '0);

    assign o_job_take = (r_state == S_IDLE) && i_job.valid;
    assign o_out_push = ((r_state == S_SIGN) || ((r_state == S_EMIT) && !skip)) && !i_out_full;
    assign o_out_char = (r_state == S_SIGN) ? sitda_pkg::CHAR_MINUS
                                            : sitda_pkg::CHAR_ZERO + {4'd0, digit};
    assign o_out_last = (r_state == S_EMIT) && (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job.valid) begin
                        r_neg   <= i_job.neg;
                        r_sh    <= i_job_mag;
                        r_bcd   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bcd <= {bcd_adj[BW-2:0], r_sh[DATA_BITS-1]};
                    r_sh  <= {r_sh[DATA_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(DATA_BITS - 1)) begin
                        r_idx     <= IW'(NDIG - 1);
                        r_started <= 1'b0;
                        r_state   <= r_neg ? S_SIGN : S_EMIT;
                    end
                end
                S_SIGN: begin
                    if (!i_out_full) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (skip) begin
                        r_idx <= r_idx - IW'(1);
                    end else if (!i_out_full) begin
                        r_started <= 1'b1;
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx - IW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SITDA_ASSERT(a_push_room, i_clk, i_rst_n, !o_out_push || !i_out_full)
    `SITDA_ASSERT(a_sign_neg, i_clk, i_rst_n, (r_state != S_SIGN) || r_neg)
    `SITDA_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_out_push && o_out_last, r_state == S_IDLE)
    `SITDA_ASSERT_NEXT(a_take_conv, i_clk, i_rst_n, o_job_take, (r_state == S_CONV) && (r_cnt == '0))

endmodule
